// File: hdl/bhpq_pkg.sv
package bhpq_pkg;

	localparam int ID_W = 8;
	localparam int TASK_KEY_W = 32;
	localparam int CNT_W = 7;

	typedef enum logic [1:0] {
		REQ_INSERT  = 2'd0,
		REQ_EXTRACT = 2'd1,
		REQ_REMOVE  = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [ID_W-1:0]       task_id;
		logic [TASK_KEY_W-1:0] task_key;
	} req_item_t;

	typedef struct packed {
		logic [1:0]            status;
		logic                  top_valid;
		logic [ID_W-1:0]       top_id;
		logic [TASK_KEY_W-1:0] top_key;
		logic [CNT_W-1:0]      entry_count;
	} rsp_item_t;

endpackage

// File: hdl/bhpq_if.sv
interface bhpq_req_if;
	logic                     valid;
	logic                     ready;
	bhpq_pkg::req_item_t      data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bhpq_rsp_if;
	logic                     valid;
	logic                     ready;
	bhpq_pkg::rsp_item_t      data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/binary_heap_priority_queue.sv
// sequence: a failed or unused request goes straight to the root read and result load; insert
//   sifts up one parent at a time and writes the entry where it stops; extract moves the last
//   entry into the root and sifts it down; remove searches slot by slot, then fills like extract
// flow: one request at a time, taken only while the sequencer is idle; the heap has a single read
//   port and a shared comparator; a waiting result holds the sequencer only at the result load
// reset: arst_n clears count, mode, sequencer and result valid; heap memory is not cleared
module binary_heap_priority_queue #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	bhpq_req_if.sink   req,
	bhpq_rsp_if.source rsp
);
	import bhpq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int EW = ID_W + KEY_BITS;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_SRCH  = 13'b0000000000010,
		S_SRCHW = 13'b0000000000100,
		S_LDRD  = 13'b0000000001000,
		S_LDW   = 13'b0000000010000,
		S_UPRD  = 13'b0000000100000,
		S_UPCMP = 13'b0000001000000,
		S_WR    = 13'b0000010000000,
		S_DNRD  = 13'b0000100000000,
		S_DNL   = 13'b0001000000000,
		S_DNCMP = 13'b0010000000000,
		S_TOP   = 13'b0100000000000,
		S_TOPW  = 13'b1000000000000
	} state_t;

	state_t          state_q;
	logic [LW-1:0]   fill_q;
	logic            mode_q;
	logic [AW-1:0]   pos_q;      // slot of the hole that the moving entry fills
	logic [EW-1:0]   cur_q;      // the moving entry
	logic [LW-1:0]   scan_q;
	logic [EW-1:0]   best_q;
	logic [AW-1:0]   bpos_q;
	logic            bchg_q;
	logic            chk_q;      // first sift-up compare of a delete, falls back to sift down
	logic [1:0]      status_q;
	logic [ID_W-1:0] rid_q;
	rsp_item_t       out_q;
	logic            out_v_q;

	// heap memory, one write and one registered read per cycle
	logic [EW-1:0]   mem [CAPACITY];
	logic            we;
	logic [AW-1:0]   wa, ra;
	logic [EW-1:0]   wd, rd_q;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	// shared comparator: a outranks b
	logic [EW-1:0] cmp_a, cmp_b;
	logic          cmp_win;
	always_comb begin
		if (mode_q) cmp_win = cmp_a[KEY_BITS-1:0] > cmp_b[KEY_BITS-1:0];
		else        cmp_win = cmp_a[KEY_BITS-1:0] < cmp_b[KEY_BITS-1:0];
	end

	logic [AW:0]   lchild, rchild;
	logic [AW-1:0] parent;
	logic          lft_ok, rgt_ok;
	assign parent = (pos_q - AW'(1)) >> 1;
	assign lchild = {pos_q, 1'b1};
	assign rchild = lchild + (AW+1)'(1);
	assign lft_ok = lchild < (AW+1)'(fill_q);
	assign rgt_ok = rchild < (AW+1)'(fill_q);

	logic [LW-1:0] last;
	assign last = fill_q - LW'(1);

	logic [KEY_BITS-1:0] in_key;
	assign in_key = KEY_BITS'(req.data.task_key);

	// result register loads when empty or when its beat leaves
	logic out_load;
	assign out_load = (state_q == S_TOPW) && (!out_v_q || rsp.ready);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	// address, write and comparator operand control
	always_comb begin
		we = 1'b0;
		wa = pos_q;
		wd = cur_q;
		ra = '0;
		cmp_a = cur_q;
		cmp_b = rd_q;
		case (state_q)
			S_SRCH:  ra = scan_q[AW-1:0];
			S_LDRD:  ra = fill_q[AW-1:0];
			S_UPRD:  ra = parent;
			S_UPCMP: begin
				if (cmp_win) begin
					we = 1'b1;
					wd = rd_q;
				end else if (!chk_q) begin
					we = 1'b1;
				end
			end
			S_WR:    we = 1'b1;
			S_DNRD: begin
				if (lft_ok) ra = lchild[AW-1:0];
				else we = 1'b1;
			end
			S_DNL: begin
				ra = rchild[AW-1:0];
				cmp_a = rd_q;
				cmp_b = cur_q;
			end
			S_DNCMP: begin
				cmp_a = rd_q;
				cmp_b = best_q;
				we = 1'b1;
				wd = (rgt_ok && cmp_win) ? rd_q : best_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			mode_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) mode_q <= cfg_wdata;
			if (out_load) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						status_q <= ST_OK;
						rid_q    <= req.data.task_id;
						chk_q    <= 1'b0;
						case (req_t'(req.data.req_type))
							REQ_INSERT: begin
								if (fill_q >= LW'(CAPACITY)) begin
									status_q <= ST_FULL;
									state_q  <= S_TOP;
								end else begin
									cur_q   <= {req.data.task_id, in_key};
									pos_q   <= AW'(fill_q);
									fill_q  <= fill_q + LW'(1);
									state_q <= (fill_q == '0) ? S_WR : S_UPRD;
								end
							end
							REQ_EXTRACT: begin
								if (fill_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_TOP;
								end else begin
									pos_q   <= '0;
									fill_q  <= last;
									state_q <= (last == '0) ? S_TOP : S_LDRD;
								end
							end
							REQ_REMOVE: begin
								scan_q  <= '0;
								state_q <= S_SRCH;
							end
							default: state_q <= S_TOP;
						endcase
					end
				end
				// linear search, one slot per S_SRCH and S_SRCHW pair
				S_SRCH: begin
					if (scan_q >= fill_q) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_TOP;
					end else begin
						state_q <= S_SRCHW;
					end
				end
				S_SRCHW: begin
					if (rd_q[EW-1 -: ID_W] == rid_q) begin
						pos_q   <= scan_q[AW-1:0];
						fill_q  <= last;
						state_q <= (scan_q == last) ? S_TOP : S_LDRD;
					end else begin
						scan_q  <= scan_q + LW'(1);
						state_q <= S_SRCH;
					end
				end
				// fetch the last entry into the hole
				S_LDRD: state_q <= S_LDW;
				S_LDW: begin
					cur_q <= rd_q;
					if (pos_q == '0) begin
						state_q <= S_DNRD;
					end else begin
						chk_q   <= 1'b1;
						state_q <= S_UPRD;
					end
				end
				// sift up, parent moves down into the hole
				S_UPRD: state_q <= S_UPCMP;
				S_UPCMP: begin
					chk_q <= 1'b0;
					if (cmp_win) begin
						pos_q   <= parent;
						state_q <= (parent == '0) ? S_WR : S_UPRD;
					end else if (chk_q) begin
						state_q <= S_DNRD;
					end else begin
						state_q <= S_TOP;
					end
				end
				S_WR: state_q <= S_TOP;
				// sift down, best child moves up into the hole
				S_DNRD: begin
					if (lft_ok) state_q <= S_DNL;
					else state_q <= S_TOP;
				end
				S_DNL: begin
					if (cmp_win) begin
						best_q <= rd_q;
						bpos_q <= lchild[AW-1:0];
						bchg_q <= 1'b1;
					end else begin
						best_q <= cur_q;
						bpos_q <= pos_q;
						bchg_q <= 1'b0;
					end
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					if (rgt_ok && cmp_win) begin
						pos_q   <= rchild[AW-1:0];
						state_q <= S_DNRD;
					end else if (bchg_q) begin
						pos_q   <= bpos_q;
						state_q <= S_DNRD;
					end else begin
						state_q <= S_TOP;
					end
				end
				// read the root and load the result
				S_TOP: state_q <= S_TOPW;
				S_TOPW: begin
					if (out_load) begin
						out_q.status      <= status_q;
						out_q.top_valid   <= fill_q != '0;
						out_q.top_id      <= (fill_q != '0) ? rd_q[EW-1 -: ID_W] : '0;
						out_q.top_key     <= (fill_q != '0) ?
							TASK_KEY_W'(rd_q[KEY_BITS-1:0]) : '0;
						out_q.entry_count <= CNT_W'(fill_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: dv/tb_binary_heap_priority_queue.sv
`timescale 1ns / 100ps

module tb_binary_heap_priority_queue;
	import bhpq_pkg::*;

	localparam int CAP = 64;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	bhpq_req_if req_ch ();
	bhpq_rsp_if rsp_ch ();

	binary_heap_priority_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch.sink),
		.rsp       (rsp_ch.source)
	);

	// shadow heap
	logic [7:0]  sh_ids[CAP];
	logic [31:0] sh_keys[CAP];
	int          sh_fill;
	logic        sh_max;

	rsp_item_t expected_rsp_q[$];
	int        err_count;
	int        cycle_count;
	bit        idle_on;
	bit        final_phase;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_binary_heap_priority_queue: errors");
			$finish;
		end
	end

	function automatic bit outranks(logic [31:0] a, logic [31:0] b);
		return sh_max ? (a > b) : (a < b);
	endfunction

	function automatic void swap_slots(int a, int b);
		logic [7:0]  ti;
		logic [31:0] tk;
		ti = sh_ids[a];
		tk = sh_keys[a];
		sh_ids[a] = sh_ids[b];
		sh_keys[a] = sh_keys[b];
		sh_ids[b] = ti;
		sh_keys[b] = tk;
	endfunction

	function automatic void sift_up(int pos);
		int parent;
		while (pos > 0) begin
			parent = (pos - 1) / 2;
			if (!outranks(sh_keys[pos], sh_keys[parent]))
				break;
			swap_slots(pos, parent);
			pos = parent;
		end
	endfunction

	function automatic void sift_down(int pos);
		int l, r, best;
		while (pos < sh_fill) begin
			l = 2 * pos + 1;
			r = 2 * pos + 2;
			best = pos;
			if (l < sh_fill && outranks(sh_keys[l], sh_keys[best]))
				best = l;
			if (r < sh_fill && outranks(sh_keys[r], sh_keys[best]))
				best = r;
			if (best == pos)
				break;
			swap_slots(pos, best);
			pos = best;
		end
	endfunction

	function automatic void delete_slot(int pos);
		sh_fill--;
		if (pos != sh_fill) begin
			sh_ids[pos] = sh_ids[sh_fill];
			sh_keys[pos] = sh_keys[sh_fill];
			if (pos > 0 && outranks(sh_keys[pos], sh_keys[(pos - 1) / 2]))
				sift_up(pos);
			else
				sift_down(pos);
		end
	endfunction

	// apply one request to the shadow heap and queue the expected response
	function automatic void predict_heap(req_item_t it);
		rsp_item_t r;
		status_t   st;
		st = ST_OK;
		case (req_t'(it.req_type))
			REQ_INSERT: begin
				if (sh_fill >= CAP) begin
					st = ST_FULL;
				end else begin
					sh_ids[sh_fill] = it.task_id;
					sh_keys[sh_fill] = it.task_key;
					sh_fill++;
					sift_up(sh_fill - 1);
				end
			end
			REQ_EXTRACT: begin
				if (sh_fill == 0)
					st = ST_EMPTY;
				else
					delete_slot(0);
			end
			REQ_REMOVE: begin
				st = ST_NOT_FOUND;
				for (int i = 0; i < sh_fill; i++) begin
					if (sh_ids[i] == it.task_id) begin
						delete_slot(i);
						st = ST_OK;
						break;
					end
				end
			end
			default: ;
		endcase
		r.status = st;
		r.top_valid = (sh_fill > 0);
		r.top_id = (sh_fill > 0) ? sh_ids[0] : '0;
		r.top_key = (sh_fill > 0) ? sh_keys[0] : '0;
		r.entry_count = sh_fill[6:0];
		expected_rsp_q.push_back(r);
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	// sink side: random stalls, check each response beat
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!idle_on || final_phase || $urandom_range(0, 5) != 0) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				stall = $urandom_range(1, 18);
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		rsp_item_t got, exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.data;
			if (expected_rsp_q.size() == 0) begin
				report_mismatch("response beat with nothing expected");
			end else begin
				exp_r = expected_rsp_q.pop_front();
				if (got.status !== exp_r.status)
					report_mismatch($sformatf("status %0d exp %0d", got.status,
						exp_r.status));
				if (got.top_valid !== exp_r.top_valid)
					report_mismatch($sformatf("top_valid %0b exp %0b", got.top_valid,
						exp_r.top_valid));
				if (got.top_id !== exp_r.top_id)
					report_mismatch($sformatf("top_id %0d exp %0d", got.top_id,
						exp_r.top_id));
				if (got.top_key !== exp_r.top_key)
					report_mismatch($sformatf("top_key %h exp %h", got.top_key,
						exp_r.top_key));
				if (got.entry_count !== exp_r.entry_count)
					report_mismatch($sformatf("entry_count %0d exp %0d",
						got.entry_count, exp_r.entry_count));
			end
		end
	end

	// send one request beat, with an optional random gap first; valid stays up
	// after the accepting edge so the next beat can follow back to back
	task automatic send_req(req_t kind, logic [7:0] id, logic [31:0] key);
		req_item_t it;
		if (idle_on && !final_phase && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		it.req_type = kind;
		it.task_id = id;
		it.task_key = key;
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		do @(posedge clk); while (!req_ch.ready);
		predict_heap(it);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_mode(logic m);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sh_max = m;
	endtask

	task automatic drain_heap();
		while (sh_fill > 0)
			send_req(REQ_EXTRACT, 8'($urandom), $urandom);
	endtask

	// empty heap cases, extremes, unused code, remove hit and miss
	task automatic test_directed();
		send_req(REQ_EXTRACT, 8'd0, 32'd0);
		send_req(REQ_REMOVE, 8'd5, 32'd0);
		send_req(REQ_NONE, 8'hff, 32'hffff_ffff);
		send_req(REQ_INSERT, 8'd0, 32'd0);
		send_req(REQ_INSERT, 8'hff, 32'hffff_ffff);
		send_req(REQ_INSERT, 8'h55, 32'h8000_0000);
		send_req(REQ_INSERT, 8'haa, 32'h8000_0000);
		send_req(REQ_NONE, 8'd0, 32'd0);
		send_req(REQ_REMOVE, 8'h12, 32'd0);
		send_req(REQ_REMOVE, 8'h55, 32'h1234);
		send_req(REQ_EXTRACT, 8'd0, 32'd0);
		send_req(REQ_REMOVE, 8'd0, 32'd0);
		send_req(REQ_EXTRACT, 8'd0, 32'd0);
		send_req(REQ_EXTRACT, 8'd0, 32'd0);
	endtask

	// fill to capacity, insert on full, remove the last and a random entry, then drain
	task automatic test_full(bit equal_keys);
		while (sh_fill < CAP)
			send_req(REQ_INSERT, 8'($urandom), equal_keys ? 32'd7 : $urandom_range(0, 40));
		send_req(REQ_INSERT, 8'h3c, 32'd1);
		send_req(REQ_REMOVE, sh_ids[CAP - 1], 32'd0);
		send_req(REQ_REMOVE, sh_ids[$urandom_range(0, CAP - 2)], 32'd0);
		drain_heap();
	endtask

	// random mix biased toward a mid-sized heap, small id range for matches
	task automatic test_random(int n);
		int   sel;
		req_t kind;
		logic [31:0] key;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sh_fill < 10)
				kind = (sel < 75) ? REQ_INSERT : (sel < 88) ? REQ_EXTRACT :
					(sel < 97) ? REQ_REMOVE : REQ_NONE;
			else
				kind = (sel < 45) ? REQ_INSERT : (sel < 72) ? REQ_EXTRACT :
					(sel < 97) ? REQ_REMOVE : REQ_NONE;
			case ($urandom_range(0, 3))
				0: key = $urandom;
				1: key = $urandom_range(0, 15);
				2: key = 32'hffff_fff0 | $urandom_range(0, 15);
				default: key = $urandom_range(0, 1000);
			endcase
			send_req(kind,
				8'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 31)), key);
		end
	endtask

	initial begin
		cycle_count = 0;
		err_count = 0;
		sh_fill = 0;
		sh_max = 1'b0;
		idle_on = 1'b0;
		final_phase = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		set_mode(1'b1);
		test_directed();
		idle_on = 1'b1;
		test_full(1'b0);
		set_mode(1'b0);
		test_full(1'b1);
		test_random(120);
		// mode change with entries held: no reordering
		set_mode(1'b1);
		test_random(100);
		set_mode(1'b0);
		test_random(60);
		final_phase = 1'b1;
		test_random(60);
		wait_drained();

		if (err_count == 0)
			$display("tb_binary_heap_priority_queue: clean");
		else
			$display("tb_binary_heap_priority_queue: errors");
		$finish;
	end

endmodule
